@@ rtl/ptc_pkg.sv @@
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants of the polyline tile clipper.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int LAT_W  = 27;
    localparam int LON_W  = 28;
    localparam int TILE_W = 14;

    localparam int UNITS_PER_DEG = 600000;
    localparam int TILES_PER_ROW = 180;
    localparam int LAT_TOP_DEG   = 90;
    localparam int TILE_MAX      = 180 * 90;
    localparam int BOX_SPAN      = 2 * UNITS_PER_DEG;

    // tile / 180 estimate: (tile * 91) >> 14, low by at most one
    localparam int RECIP_MUL   = 91;
    localparam int RECIP_SHIFT = 14;

    // cycles from a tile write until the box bounds are settled
    localparam int BOX_LATENCY = 4;

    typedef struct packed {
        logic signed [LAT_W-1:0] point_lat;
        logic signed [LON_W-1:0] point_lon;
        logic                    point_is_last;
    } in_t;

    typedef struct packed {
        logic signed [LAT_W-1:0] clip_lat;
        logic signed [LON_W-1:0] clip_lon;
        logic                    clip_is_last;
    } out_t;

    typedef struct packed {
        logic                    ready;
        logic                    ok;
        logic signed [LAT_W-1:0] lat_lo;
        logic signed [LAT_W-1:0] lat_hi;
        logic signed [LON_W-1:0] lon_lo;
        logic signed [LON_W-1:0] lon_hi;
    } box_t;

endpackage

@@ rtl/polyline_tile_clipper.sv @@
// ----------------------------------------------------------------------------
// polyline_tile_clipper
// Clips a stream of polyline points to a 2 by 2 degree map tile.
// ----------------------------------------------------------------------------
// Points enter one per request on the s_ channel and are held in an input
// register; the clip decision for that point is made from that register and
// its results (none to three) are written into a small output queue that
// drives the m_ channel, one result per request. With at most one result
// per point, settled bounds and m_ready held high, the block sustains one
// point per clock; a point that gives more results than there is queue room
// waits in the input register. After reset, and after every write of the
// tile number, the box bounds settle in the bounds pipeline (a 14 bit by
// constant estimate of tile/180, a remainder fix-up, then two constant
// multiplies and the span offsets); points are not processed until the
// bounds are settled.
// ----------------------------------------------------------------------------
module polyline_tile_clipper #(
    parameter int QUEUE_DEPTH = 4     // result queue entries, at least 3
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [ptc_pkg::TILE_W-1:0]  cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  ptc_pkg::in_t                s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output ptc_pkg::out_t               m_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // box bounds from the tile register
    ptc_pkg::box_t box;

    ptc_box_gen u_box (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tile_wr_en   (cfg_wr_en),
        .tile_wr_data (cfg_wr_data),
        .box          (box)
    );

    // input register
    ptc_pkg::in_t in_reg;
    logic         in_valid_reg;

    // clipper state
    logic                             run_inside_reg;
    logic                             prev_valid_reg;
    logic signed [ptc_pkg::LAT_W-1:0] prev_lat_reg;
    logic signed [ptc_pkg::LON_W-1:0] prev_lon_reg;
    logic                             held_valid_reg;
    logic signed [ptc_pkg::LAT_W-1:0] held_lat_reg;
    logic signed [ptc_pkg::LON_W-1:0] held_lon_reg;
    logic [1:0]                       emit_cnt_reg;

    // result queue, head always at entry 0
    ptc_pkg::out_t q_reg  [QUEUE_DEPTH];
    ptc_pkg::out_t q_next [QUEUE_DEPTH];
    logic [CW-1:0] q_count_reg;
    logic [CW-1:0] q_count_next;
    logic [CW-1:0] q_base;
    logic [CW-1:0] q_off;
    logic          pop;

    // decision logic
    logic          in_box;
    logic          same_as_prev;
    logic [1:0]    app_len;
    logic          e0_valid;
    logic          e1_valid;
    logic          e2_valid;
    ptc_pkg::out_t e0;
    ptc_pkg::out_t e1;
    ptc_pkg::out_t e2;
    ptc_pkg::out_t cand [3];
    logic [1:0]    res_n;
    logic          held_valid_next;
    logic [2:0]    cnt_sum;
    logic [1:0]    emit_cnt_next;
    logic          proc;

    always_comb begin
        in_box = box.ok
              && in_reg.point_lat >= box.lat_lo && in_reg.point_lat <= box.lat_hi
              && in_reg.point_lon >= box.lon_lo && in_reg.point_lon <= box.lon_hi;
        same_as_prev = (prev_lat_reg == in_reg.point_lat)
                    && (prev_lon_reg == in_reg.point_lon);

        // points appended to the delay line: entry point (if any), then current
        if (in_box && !run_inside_reg && prev_valid_reg && !same_as_prev) begin
            app_len = 2'd2;
        end else if (in_box || run_inside_reg) begin
            app_len = 2'd1;
        end else begin
            app_len = 2'd0;
        end

        // each append pushes out whatever the delay line held
        e0_valid = held_valid_reg && (app_len != 2'd0);
        e0       = '{clip_lat: held_lat_reg, clip_lon: held_lon_reg, clip_is_last: 1'b0};
        e1_valid = (app_len == 2'd2);
        e1       = '{clip_lat: prev_lat_reg, clip_lon: prev_lon_reg, clip_is_last: 1'b0};

        held_valid_next = held_valid_reg || (app_len != 2'd0);
        cnt_sum = 3'(emit_cnt_reg) + 3'(e0_valid) + 3'(e1_valid);
        emit_cnt_next = (cnt_sum > 3'd3) ? 2'd3 : 2'(cnt_sum);

        // end of polyline: flush the delay line unless it is a lone point
        e2_valid = in_reg.point_is_last && held_valid_next && (emit_cnt_next != 2'd0);
        if (app_len != 2'd0) begin
            e2 = '{clip_lat: in_reg.point_lat, clip_lon: in_reg.point_lon,
                   clip_is_last: 1'b1};
        end else begin
            e2 = '{clip_lat: held_lat_reg, clip_lon: held_lon_reg, clip_is_last: 1'b1};
        end

        res_n = 2'(e0_valid) + 2'(e1_valid) + 2'(e2_valid);

        // pack valid results to the front
        cand[0] = e0_valid ? e0 : (e1_valid ? e1 : e2);
        cand[1] = (e0_valid && e1_valid) ? e1 : e2;
        cand[2] = e2;

        // room is judged without this cycle's pop: keeps m_ready off s_ready
        proc = in_valid_reg && box.ready
            && ((CW+1)'(q_count_reg) + (CW+1)'(res_n) <= (CW+1)'(QUEUE_DEPTH));
    end

    assign s_ready = !in_valid_reg || proc;
    assign m_valid = (q_count_reg != '0);
    assign m_data  = q_reg[0];
    assign pop     = m_valid && m_ready;

    // queue next state: shift on pop, then place new results after the tail
    always_comb begin
        q_base = q_count_reg - CW'(pop);
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            q_next[i] = pop ? q_reg[i+1] : q_reg[i];
        end
        q_next[QUEUE_DEPTH-1] = q_reg[QUEUE_DEPTH-1];
        q_off = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (proc && CW'(i) >= q_base
                && (CW+1)'(i) < (CW+1)'(q_base) + (CW+1)'(res_n)) begin
                q_off = CW'(i) - q_base;
                case (q_off)
                    CW'(0):  q_next[i] = cand[0];
                    CW'(1):  q_next[i] = cand[1];
                    default: q_next[i] = cand[2];
                endcase
            end
        end
        q_count_next = q_base + (proc ? CW'(res_n) : CW'(0));
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (proc) begin
            prev_lat_reg <= in_reg.point_lat;
            prev_lon_reg <= in_reg.point_lon;
            if (app_len != 2'd0) begin
                held_lat_reg <= in_reg.point_lat;
                held_lon_reg <= in_reg.point_lon;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            q_count_reg    <= '0;
            run_inside_reg <= 1'b0;
            prev_valid_reg <= 1'b0;
            held_valid_reg <= 1'b0;
            emit_cnt_reg   <= 2'd0;
        end else begin
            q_count_reg <= q_count_next;
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (proc) begin
                in_valid_reg <= 1'b0;
            end
            if (proc) begin
                if (in_reg.point_is_last) begin
                    run_inside_reg <= 1'b0;
                    prev_valid_reg <= 1'b0;
                    held_valid_reg <= 1'b0;
                    emit_cnt_reg   <= 2'd0;
                end else begin
                    run_inside_reg <= in_box;
                    prev_valid_reg <= 1'b1;
                    held_valid_reg <= held_valid_next;
                    emit_cnt_reg   <= emit_cnt_next;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count_reg <= CW'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_cfg_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !proc)
        else $error("point processed while box bounds settle");

    a_cnt_needs_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !held_valid_reg |-> (emit_cnt_reg == 2'd0))
        else $error("emitted count without a held point");

    a_run_needs_prev: assert property (@(posedge aclk) disable iff (!aresetn)
        !prev_valid_reg |-> !run_inside_reg)
        else $error("inside run flagged with no previous point");

endmodule

@@ rtl/ptc_box_gen.sv @@
// ----------------------------------------------------------------------------
// ptc_box_gen
// Holds the tile number and derives the clipping box bounds from it over a
// short pipeline; flags when the bounds are settled.
// ----------------------------------------------------------------------------
module ptc_box_gen (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        tile_wr_en,
    input  logic [ptc_pkg::TILE_W-1:0]  tile_wr_data,
    output ptc_pkg::box_t               box
);

    localparam int BUSY_W = $clog2(ptc_pkg::BOX_LATENCY + 1);

    logic [ptc_pkg::TILE_W-1:0]      tile_reg;
    logic [BUSY_W-1:0]               busy_reg;
    logic                            box_ok_reg;
    logic [ptc_pkg::TILE_W-1:0]      tile_b_reg;
    logic [6:0]                      q0_reg;
    logic [6:0]                      row_reg;
    logic [7:0]                      col_reg;
    logic signed [ptc_pkg::LAT_W-1:0] lat_hi_reg;
    logic signed [ptc_pkg::LAT_W-1:0] lat_lo_reg;
    logic signed [ptc_pkg::LON_W-1:0] lon_lo_reg;
    logic signed [ptc_pkg::LON_W-1:0] lon_hi_reg;

    logic [20:0]       recip_prod;
    logic [13:0]       q0_x180;
    logic [8:0]        rem;
    logic [6:0]        row_next;
    logic [7:0]        col_next;
    logic signed [8:0] lat_hi_deg;
    logic signed [9:0] lon_lo_deg;
    logic signed [31:0] lat_hi_prod;
    logic signed [31:0] lon_lo_prod;

    always_comb begin
        recip_prod  = 21'(tile_reg) * 21'(ptc_pkg::RECIP_MUL);
        q0_x180     = 14'(q0_reg) * 14'(ptc_pkg::TILES_PER_ROW);
        rem         = 9'(tile_b_reg - q0_x180);
        if (rem >= 9'(ptc_pkg::TILES_PER_ROW)) begin
            row_next = q0_reg + 7'd1;
            col_next = 8'(rem - 9'(ptc_pkg::TILES_PER_ROW));
        end else begin
            row_next = q0_reg;
            col_next = 8'(rem);
        end
        lat_hi_deg  = 9'(ptc_pkg::LAT_TOP_DEG) - $signed({1'b0, row_reg, 1'b0});
        lon_lo_deg  = $signed({1'b0, col_reg, 1'b0}) - 10'(ptc_pkg::TILES_PER_ROW);
        lat_hi_prod = lat_hi_deg * ptc_pkg::UNITS_PER_DEG;
        lon_lo_prod = lon_lo_deg * ptc_pkg::UNITS_PER_DEG;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_reg <= '0;
            busy_reg <= BUSY_W'(ptc_pkg::BOX_LATENCY);
        end else begin
            if (tile_wr_en) begin
                tile_reg <= tile_wr_data;
                busy_reg <= BUSY_W'(ptc_pkg::BOX_LATENCY);
            end else if (busy_reg != '0) begin
                busy_reg <= busy_reg - BUSY_W'(1);
            end
        end
    end

    // bounds pipeline, free running
    always_ff @(posedge aclk) begin
        box_ok_reg <= (tile_reg <= ptc_pkg::TILE_W'(ptc_pkg::TILE_MAX));
        tile_b_reg <= tile_reg;
        q0_reg     <= 7'(recip_prod >> ptc_pkg::RECIP_SHIFT);
        row_reg    <= row_next;
        col_reg    <= col_next;
        lat_hi_reg <= ptc_pkg::LAT_W'(lat_hi_prod);
        lon_lo_reg <= ptc_pkg::LON_W'(lon_lo_prod);
        lat_lo_reg <= lat_hi_reg - ptc_pkg::LAT_W'(ptc_pkg::BOX_SPAN);
        lon_hi_reg <= lon_lo_reg + ptc_pkg::LON_W'(ptc_pkg::BOX_SPAN);
    end

    assign box.ready  = (busy_reg == '0);
    assign box.ok     = box_ok_reg;
    assign box.lat_lo = lat_lo_reg;
    assign box.lat_hi = lat_hi_reg;
    assign box.lon_lo = lon_lo_reg;
    assign box.lon_hi = lon_hi_reg;

endmodule
